// ----- design/pslb_pkg.sv -----
// Shared types, constants and control structs of the per-source leaky-bucket limiter.
package pslb_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int ADDR_W     = 32;
  localparam int LEVEL_W    = 32;
  localparam int TIME_W     = 40;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int MUL_A_W    = TIME_W;
  localparam int MUL_B_W    = CFG_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam int REQ_COST      = 1000;
  localparam int ALLOW_LIMIT   = 1000;
  localparam int MS_PER_MIN    = 60;
  localparam int RATE_RESET    = 60;
  localparam int PENALTY_RESET = 0;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY = 1'b1;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
  // Any product at or above this gives a quotient by 60 that no level can hold.
  localparam logic [PROD_W-1:0]  BIG_LIMIT = PROD_W'(MS_PER_MIN) << LEVEL_W;

  // Division by 60 multiplies by ceil(2^44 / 60), one 16-bit slice of the
  // constant per cycle. It is exact for every dividend below BIG_LIMIT.
  localparam int          DIV_CHUNK_W = MUL_B_W;
  localparam int          DIV_STEPS   = 3;
  localparam int          DIV_SHIFT   = 12;
  localparam logic [47:0] DIV_RECIP   = 48'h0044_4444_4445;
  localparam int          DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {
    OP_CHECK   = 2'd0,
    OP_REQUEST = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_SWEEP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                opcode;
    logic [ADDR_W-1:0]  source_address;
    logic [TIME_W-1:0]  now_ms;
  } req_t;

  typedef struct packed {
    logic               allowed;
    logic               status;
    logic [LEVEL_W-1:0] bucket_level;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  last_time;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  typedef enum logic [1:0] {
    MUL_DECAY,
    MUL_PEN,
    MUL_K,
    MUL_RECIP
  } mul_sel_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_ALLOW,
    RES_FULL,
    RES_LEVEL
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_SW_RD,
    S_SW_CAP,
    S_DEC_MUL,
    S_PEN_MUL,
    S_K_MUL,
    S_DIV_LD,
    S_DIV,
    S_DECAY,
    S_DEC_END,
    S_ADD,
    S_WB,
    S_DONE
  } state_t;

  typedef struct packed {
    logic      load_in;
    logic      scan_start;
    logic      scan_run;
    logic      cap_scan;
    logic      cap_rd;
    logic      ent_new;
    logic      sw_adv;
    logic      sw_rd;
    logic      mul_en;
    mul_sel_t  mul_sel;
    logic      div_start;
    logic      div_step;
    logic      decay_back;
    logic      decay_apply;
    logic      add_apply;
    logic      wr;
    logic      free_clear;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic match;
    logic scan_done;
    logic free_found;
    logic sweep_valid;
    logic time_back;
    logic time_same;
    logic div_done;
    logic lvl_zero;
  } sts_t;

endpackage

// ----- design/per_source_leaky_bucket_limiter.sv -----
// Top level of the per-source leaky-bucket rate limiter.
//
// Request channel (req_valid, req_stall, req_data): one transfer carries an
// opcode, a source address and the current millisecond time. The block takes
// one request at a time; req_stall is low only while it is idle.
// Response channel (rsp_valid, rsp_stall, rsp_data): exactly one response
// per request, in request order. The response sits in an output register,
// so the next request is taken while it waits for the receiver.
// A check, request or timeout scans the table one slot per cycle and stops
// at a hit. On a miss a check is answered as allowed, while an inserting
// request or timeout goes on to its addition or its penalty arithmetic; a
// hit's time is set by the slot and by the multiply and the reciprocal
// divide by 60. A sweep step skips the scan. The next request is taken in
// the cycle after the response is loaded.
// Configuration (cfg_we, cfg_index, cfg_data) writes the rate or the timeout
// penalty and must only be used while the block is idle.
// Reset (rst, synchronous) empties the table, zeroes the sweep pointer and
// restores a rate of 60 units per 60 ms and no penalty; no clearing pass is needed.
// While the receiver stalls, a finished response holds, and a further
// request waits in its final state until the output register frees.
module per_source_leaky_bucket_limiter import pslb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Command and status between the controller and the datapath.
  cmd_t cmd;
  sts_t st;

  pslb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath owns the table, the per-slot valid bits, the configuration
  // registers, the arithmetic and the output payload register.
  pslb_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .st       (st),
    .rsp      (rsp_data)
  );

endmodule

// ----- design/pslb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pslb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/pslb_datapath.sv -----
// Datapath of the limiter: table storage, key scan, multiplier, divider by 60 and result register.
module pslb_datapath import pslb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 st,
  output rsp_t                 rsp
);

  req_t                     cur;
  logic [CFG_W-1:0]         rate;
  logic [CFG_W-1:0]         penalty;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [IDX_W-1:0]         sweep_ptr;
  logic [IDX_W-1:0]         rd_idx;
  logic [IDX_W-1:0]         slot;
  logic [IDX_W-1:0]         free_slot;
  logic [IDX_W:0]           scan_idx;
  logic                     rd_pend;
  logic                     free_found;
  logic                     issue;
  logic                     match;

  logic [ADDR_W-1:0]        ent_addr;
  logic [LEVEL_W-1:0]       ent_level;
  logic [TIME_W-1:0]        ent_time;

  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        mul_res;
  logic [PROD_W-1:0]        prod;

  logic                     big;
  logic [PROD_W:0]          acc;
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [LEVEL_W-1:0]       quo;

  logic [LEVEL_W-1:0]       amount;
  logic [LEVEL_W:0]         sum;

  logic                     ram_re;
  logic [IDX_W-1:0]         ram_raddr;
  logic [ENT_W-1:0]         ram_rdata;
  ent_t                     rd_ent;
  ent_t                     wr_ent;

  assign rd_ent = ent_t'(ram_rdata);
  assign wr_ent = '{addr: ent_addr, level: ent_level, last_time: ent_time};

  assign issue     = cmd.scan_run && (scan_idx < (IDX_W + 1)'(TABLE_ENTRIES));
  assign ram_re    = issue || cmd.sw_rd;
  assign ram_raddr = cmd.sw_rd ? sweep_ptr : scan_idx[IDX_W-1:0];
  assign match     = rd_pend && valid[rd_idx] && (rd_ent.addr == cur.source_address);

  pslb_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(slot),
    .wdata(wr_ent),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DECAY: begin
        mul_a = cur.now_ms - ent_time;
        mul_b = rate;
      end
      MUL_PEN: begin
        mul_a = MUL_A_W'(penalty);
        mul_b = rate;
      end
      MUL_K: begin
        mul_a = MUL_A_W'(prod[LEVEL_W-1:0]);
        mul_b = MUL_B_W'(REQ_COST);
      end
      MUL_RECIP: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(DIV_RECIP >> (DIV_CHUNK_W * int'(div_cnt)));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Reciprocal division by 60. Each step adds one partial product to the
  // running sum shifted down by a slice, so after the last step acc holds
  // the full product over 2^32 and the quotient sits DIV_SHIFT bits up.
  assign quo    = acc[DIV_SHIFT +: LEVEL_W];
  assign amount = (cur.opcode == OP_REQUEST) ? LEVEL_W'(REQ_COST) : (big ? LEVEL_MAX : quo);
  assign sum    = {1'b0, ent_level} + {1'b0, amount};

  always_ff @(posedge clk) begin
    if (rst) begin
      rate       <= CFG_W'(RATE_RESET);
      penalty    <= CFG_W'(PENALTY_RESET);
      valid      <= '0;
      sweep_ptr  <= '0;
      scan_idx   <= '0;
      rd_pend    <= 1'b0;
      free_found <= 1'b0;
      div_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_RATE) begin
          rate <= cfg_data;
        end else begin
          penalty <= cfg_data;
        end
      end

      if (cmd.scan_start) begin
        scan_idx   <= '0;
        rd_pend    <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.scan_run) begin
        rd_pend <= issue;
        rd_idx  <= scan_idx[IDX_W-1:0];
        if (issue) begin
          scan_idx <= scan_idx + 1'b1;
          if (!free_found && !valid[scan_idx[IDX_W-1:0]]) begin
            free_found <= 1'b1;
            free_slot  <= scan_idx[IDX_W-1:0];
          end
        end
      end

      if (cmd.sw_adv) begin
        if (sweep_ptr == IDX_W'(TABLE_ENTRIES - 1)) begin
          sweep_ptr <= '0;
        end else begin
          sweep_ptr <= sweep_ptr + 1'b1;
        end
      end

      if (cmd.wr) begin
        valid[slot] <= 1'b1;
      end else if (cmd.free_clear) begin
        valid[slot] <= 1'b0;
      end

      if (cmd.div_start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur <= req;
    end

    if (cmd.cap_scan && match) begin
      ent_addr  <= rd_ent.addr;
      ent_level <= rd_ent.level;
      ent_time  <= rd_ent.last_time;
      slot      <= rd_idx;
    end else if (cmd.cap_rd) begin
      ent_addr  <= rd_ent.addr;
      ent_level <= rd_ent.level;
      ent_time  <= rd_ent.last_time;
    end else if (cmd.ent_new) begin
      ent_addr  <= cur.source_address;
      ent_level <= '0;
      ent_time  <= cur.now_ms;
      slot      <= free_slot;
    end else if (cmd.decay_back) begin
      ent_time <= cur.now_ms;
    end else if (cmd.decay_apply) begin
      // A zero drop leaves the entry, time stamp included, untouched.
      if (big || (quo != '0)) begin
        if (big || (quo >= ent_level)) begin
          ent_level <= '0;
        end else begin
          ent_level <= ent_level - quo;
        end
        ent_time <= cur.now_ms;
      end
    end else if (cmd.add_apply) begin
      ent_level <= sum[LEVEL_W] ? LEVEL_MAX : sum[LEVEL_W-1:0];
    end

    if (cmd.sw_rd) begin
      slot <= sweep_ptr;
    end

    if (cmd.mul_en) begin
      prod <= mul_res;
    end

    if (cmd.div_start) begin
      acc <= '0;
      big <= (prod >= BIG_LIMIT);
    end else if (cmd.div_step) begin
      acc <= (acc >> DIV_CHUNK_W) + (PROD_W + 1)'(mul_res);
    end

    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        RES_ZERO:  rsp <= '{allowed: 1'b0, status: 1'b0, bucket_level: '0};
        RES_ALLOW: rsp <= '{allowed: 1'b1, status: 1'b0, bucket_level: '0};
        RES_FULL:  rsp <= '{allowed: 1'b0, status: 1'b1, bucket_level: '0};
        RES_LEVEL: rsp <= '{
          allowed:      (cur.opcode == OP_CHECK) && (ent_level < LEVEL_W'(ALLOW_LIMIT)),
          status:       1'b0,
          bucket_level: ent_level
        };
        default:   rsp <= '0;
      endcase
    end
  end

  assign st.op          = cur.opcode;
  assign st.match       = match;
  assign st.scan_done   = !rd_pend && (scan_idx == (IDX_W + 1)'(TABLE_ENTRIES));
  assign st.free_found  = free_found;
  assign st.sweep_valid = valid[sweep_ptr];
  assign st.time_back   = cur.now_ms < ent_time;
  assign st.time_same   = cur.now_ms == ent_time;
  assign st.div_done    = div_cnt == DIV_CNT_W'(DIV_STEPS);
  assign st.lvl_zero    = ent_level == '0;

`ifndef ASSERT_OFF
  a_decay_no_rise: assert property (@(posedge clk) disable iff (rst)
    cmd.decay_apply |=> ent_level <= $past(ent_level))
    else $error("decay raised a bucket level");

  a_add_no_fall: assert property (@(posedge clk) disable iff (rst)
    cmd.add_apply |=> ent_level >= $past(ent_level))
    else $error("an addition lowered a bucket level");

  a_sweep_step: assert property (@(posedge clk) disable iff (rst)
    cmd.sw_adv && (sweep_ptr != IDX_W'(TABLE_ENTRIES - 1))
      |=> sweep_ptr == IDX_W'($past(sweep_ptr) + 1'b1))
    else $error("sweep pointer did not advance by one slot");

  a_sweep_wrap: assert property (@(posedge clk) disable iff (rst)
    cmd.sw_adv && (sweep_ptr == IDX_W'(TABLE_ENTRIES - 1)) |=> sweep_ptr == '0)
    else $error("sweep pointer did not wrap after the last slot");
`endif

endmodule

// ----- design/pslb_ctrl.sv -----
// Controller state machine of the limiter: sequences scan, arithmetic, write-back and result.
module pslb_ctrl import pslb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  output logic rsp_valid,
  input  logic rsp_stall,
  input  sts_t st,
  output cmd_t cmd
);

  state_t    state;
  state_t    state_next;
  res_kind_t res_kind;
  res_kind_t res_kind_next;
  logic      rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_kind  <= RES_ZERO;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_kind  <= res_kind_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    res_kind_next = res_kind;
    cmd           = '0;
    cmd.res_kind  = res_kind;
    req_stall     = 1'b1;

    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        if (st.op == OP_SWEEP) begin
          state_next = S_SW_RD;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        cmd.cap_scan = 1'b1;
        priority if (st.match) begin
          priority if (st.op == OP_CHECK) begin
            state_next = S_DEC_MUL;
          end else if (st.op == OP_REQUEST) begin
            state_next = S_ADD;
          end else begin
            state_next = S_PEN_MUL;
          end
        end else if (st.scan_done) begin
          priority if (st.op == OP_CHECK) begin
            res_kind_next = RES_ALLOW;
            state_next    = S_DONE;
          end else if (st.free_found) begin
            cmd.ent_new = 1'b1;
            state_next  = (st.op == OP_REQUEST) ? S_ADD : S_PEN_MUL;
          end else begin
            res_kind_next = RES_FULL;
            state_next    = S_DONE;
          end
        end
      end
      S_SW_RD: begin
        cmd.sw_adv = 1'b1;
        if (st.sweep_valid) begin
          cmd.sw_rd  = 1'b1;
          state_next = S_SW_CAP;
        end else begin
          res_kind_next = RES_ZERO;
          state_next    = S_DONE;
        end
      end
      S_SW_CAP: begin
        cmd.cap_rd = 1'b1;
        state_next = S_DEC_MUL;
      end
      S_DEC_MUL: begin
        priority if (st.time_back) begin
          cmd.decay_back = 1'b1;
          state_next     = S_DEC_END;
        end else if (st.time_same) begin
          state_next = S_DEC_END;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_DECAY;
          state_next  = S_DIV_LD;
        end
      end
      S_PEN_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PEN;
        state_next  = S_K_MUL;
      end
      S_K_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_K;
        state_next  = S_DIV_LD;
      end
      S_DIV_LD: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = (st.op == OP_TIMEOUT) ? S_ADD : S_DECAY;
        end else begin
          cmd.div_step = 1'b1;
          cmd.mul_sel  = MUL_RECIP;
        end
      end
      S_DECAY: begin
        cmd.decay_apply = 1'b1;
        state_next      = S_DEC_END;
      end
      S_DEC_END: begin
        if ((st.op == OP_SWEEP) && st.lvl_zero) begin
          cmd.free_clear = 1'b1;
          res_kind_next  = RES_ZERO;
        end else begin
          cmd.wr        = 1'b1;
          res_kind_next = RES_LEVEL;
        end
        state_next = S_DONE;
      end
      S_ADD: begin
        cmd.add_apply = 1'b1;
        state_next    = S_WB;
      end
      S_WB: begin
        cmd.wr        = 1'b1;
        res_kind_next = RES_LEVEL;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp_valid_next = cmd.res_load || (rsp_valid && rsp_stall);

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_START)
    else $error("an accepted transfer did not start processing");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> !cmd.res_load)
    else $error("a result was loaded over a stalled one");

  a_write_or_free: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr && cmd.free_clear))
    else $error("an entry was written and freed in the same cycle");
`endif

endmodule

// ----- bench/bucket_checker.sv -----
`timescale 1ns / 1ps
// Watches the limiter's channels, predicts every response and compares it with the block.
module bucket_checker import pslb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  req_t                 req_data,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rsp_t                 rsp_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   outstanding,
  output int                   failures
);

  logic [CFG_W-1:0]   rate;
  logic [CFG_W-1:0]   penalty;
  logic               slot_used  [TABLE_ENTRIES];
  logic [ADDR_W-1:0]  slot_addr  [TABLE_ENTRIES];
  logic [LEVEL_W-1:0] slot_level [TABLE_ENTRIES];
  logic [TIME_W-1:0]  slot_stamp [TABLE_ENTRIES];
  logic [IDX_W-1:0]   sweep_slot;
  rsp_t               predicted_q [$];
  int                 fail_cnt = 0;

  function automatic int find_source(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_used[i] && slot_addr[i] == addr) return i;
    end
    return -1;
  endfunction

  // Lazy drain of one bucket up to the given time.
  function automatic void drain_bucket(int i, logic [TIME_W-1:0] now);
    logic [63:0] drop;
    if (now < slot_stamp[i]) begin
      slot_stamp[i] = now;
    end else if (now != slot_stamp[i]) begin
      drop = 64'(now - slot_stamp[i]) * 64'(rate) / 64'(MS_PER_MIN);
      if (drop != 0) begin
        slot_level[i] = (64'(slot_level[i]) > drop) ? slot_level[i] - drop[LEVEL_W-1:0] : '0;
        slot_stamp[i] = now;
      end
    end
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t        res;
    int          i;
    logic [63:0] amount;
    logic [63:0] sum;
    res = '0;
    case (r.opcode)
      OP_CHECK: begin
        res.allowed = 1'b1;
        i = find_source(r.source_address);
        if (i >= 0) begin
          drain_bucket(i, r.now_ms);
          res.bucket_level = slot_level[i];
          res.allowed = slot_level[i] < LEVEL_W'(ALLOW_LIMIT);
        end
      end
      OP_REQUEST, OP_TIMEOUT: begin
        i = find_source(r.source_address);
        if (i < 0) begin
          // A new source takes the lowest free slot, starting empty.
          for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (i < 0 && !slot_used[k]) begin
              i = k;
              slot_used[k]  = 1'b1;
              slot_addr[k]  = r.source_address;
              slot_level[k] = '0;
              slot_stamp[k] = r.now_ms;
            end
          end
        end
        if (i < 0) begin
          res.status = 1'b1;
        end else begin
          if (r.opcode == OP_REQUEST) begin
            amount = 64'(REQ_COST);
          end else begin
            amount = 64'(REQ_COST) * 64'(penalty) * 64'(rate) / 64'(MS_PER_MIN);
          end
          sum = 64'(slot_level[i]) + amount;
          slot_level[i] = (sum > 64'(LEVEL_MAX)) ? LEVEL_MAX : sum[LEVEL_W-1:0];
          res.bucket_level = slot_level[i];
        end
      end
      default: begin
        i = int'(sweep_slot);
        if (slot_used[i]) begin
          drain_bucket(i, r.now_ms);
          if (slot_level[i] == 0) slot_used[i] = 1'b0;
          else res.bucket_level = slot_level[i];
        end
        sweep_slot = sweep_slot + 1'b1;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      rate = CFG_W'(RATE_RESET);
      penalty = CFG_W'(PENALTY_RESET);
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      sweep_slot = '0;
      predicted_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RATE:    rate = cfg_data;
          CFG_PENALTY: penalty = cfg_data;
          default:     ;
        endcase
      end
      if (req_valid && !req_stall) predicted_q.push_back(predict_response(req_data));
      if (rsp_valid && !rsp_stall) begin
        if (predicted_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: response with none pending: allowed %0b status %0b level %0d",
                     $realtime, rsp_data.allowed, rsp_data.status, rsp_data.bucket_level);
          end
        end else begin
          want = predicted_q.pop_front();
          if (rsp_data.allowed !== want.allowed || rsp_data.status !== want.status ||
              rsp_data.bucket_level !== want.bucket_level) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display({"%0t: mismatch: allowed %0b (want %0b) status %0b (want %0b) ",
                        "level %0d (want %0d)"},
                       $realtime, rsp_data.allowed, want.allowed, rsp_data.status, want.status,
                       rsp_data.bucket_level, want.bucket_level);
            end
          end
        end
      end
    end
    outstanding <= predicted_q.size();
    failures <= fail_cnt;
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Top of the limiter bench: clock, reset, stimulus, flow control and the verdict.
module tb;
  import pslb_pkg::*;

  // The random part runs in phases; each phase starts from an idle block with
  // its own rate and penalty, its own pool of source addresses and its own
  // time base somewhere in the 40-bit millisecond range.
  localparam int PHASES      = 14;
  localparam int PHASE_ITEMS = 75;
  localparam int POOL_MAX    = 100;

  localparam logic [TIME_W-1:0] TIME_TOP = '1;
  localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req_data = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   outstanding;
  int                   failures;

  // While calm is set neither side inserts gaps, so back-to-back transfers
  // and an always-ready receiver get exercised too.
  bit                   calm = 1'b0;
  logic [ADDR_W-1:0]    pool [POOL_MAX];
  logic [TIME_W-1:0]    clock_ms;

  per_source_leaky_bucket_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bucket_checker bucket_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_data    (req_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_data    (rsp_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .failures    (failures)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: the slowest legal run, with every item meeting the longest
  // sender gap and the longest receiver stall, is several times shorter.
  initial begin
    #30000000;
    $display("per_source_leaky_bucket_limiter verification failed");
    $finish;
  end

  // Gap lengths: mostly none or short, now and then a long one that can
  // outlast a whole table scan.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Receiver flow control. A stall starts at random and lasts a random
  // number of cycles, so it lands on every phase of the block's work.
  initial begin : rsp_backpressure
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) hold--;
      else if ($urandom_range(0, 7) == 0) hold = pick_gap();
      rsp_stall <= (hold > 0);
    end
  end

  // Offers one request and returns at the edge where its transfer happens.
  // Valid stays high into the next request when no gap is drawn.
  task automatic send_item(input op_t op, input logic [ADDR_W-1:0] addr,
                           input logic [TIME_W-1:0] stamp);
    req_t item;
    int   gap;
    item.opcode = op;
    item.source_address = addr;
    item.now_ms = stamp;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Drops valid and waits until every predicted response has been taken,
  // which leaves the block idle and safe for register writes.
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on consecutive cycles.
  task automatic set_limits(input logic [CFG_W-1:0] rate, input logic [CFG_W-1:0] penalty);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RATE;
    cfg_data <= rate;
    @(posedge clk);
    cfg_index <= CFG_PENALTY;
    cfg_data <= penalty;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int   roll;
    int   pool_size;
    int   sweep_share;
    op_t  op;
    logic [ADDR_W-1:0] addr;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset rate of 60 units per 60 ms and no
    // penalty. An unknown source is allowed; a first request inserts it.
    send_item(OP_CHECK,   '0, '0);
    send_item(OP_REQUEST, '0, '0);
    // Same time: no decay, a full bucket is refused.
    send_item(OP_CHECK,   '0, '0);
    // 400 ms later the bucket has drained to 600 and the source is allowed.
    send_item(OP_CHECK,   '0, TIME_W'(400));
    // Time going backward only moves the stamp; the level stays.
    send_item(OP_CHECK,   '0, TIME_W'(100));
    send_item(OP_CHECK,   '0, TIME_W'(100));
    // With no penalty a timeout inserts the highest address at zero.
    send_item(OP_TIMEOUT, ADDR_TOP, TIME_TOP);
    send_item(OP_REQUEST, ADDR_TOP, TIME_TOP);
    // Sweep of slot zero drains it empty and frees it; the address is ignored.
    send_item(OP_SWEEP,   32'h1234_5678, TIME_W'(700));
    // Slot one keeps its level, slot two is empty.
    send_item(OP_SWEEP,   '0, TIME_TOP);
    send_item(OP_SWEEP,   ADDR_TOP, TIME_TOP);
    // The freed source is unknown again.
    send_item(OP_CHECK,   '0, TIME_W'(800));

    // Largest rate and penalty: a timeout saturates the level.
    wait_idle();
    set_limits('1, '1);
    send_item(OP_TIMEOUT, ADDR_TOP, TIME_TOP);
    send_item(OP_REQUEST, ADDR_TOP, TIME_TOP);
    send_item(OP_CHECK,   ADDR_TOP, '0);

    // Slowest nonzero rate: a short interval drains nothing and keeps the
    // stamp, 60 ms of it drains one unit.
    wait_idle();
    set_limits(CFG_W'(1), '0);
    send_item(OP_REQUEST, 32'h5A5A_5A5A, TIME_W'(1000));
    send_item(OP_CHECK,   32'h5A5A_5A5A, TIME_W'(1030));
    send_item(OP_CHECK,   32'h5A5A_5A5A, TIME_W'(1060));

    // Rate zero: no drain at all and a timeout charges nothing.
    wait_idle();
    set_limits('0, CFG_W'(10));
    send_item(OP_TIMEOUT, 32'h5A5A_5A5A, TIME_W'(5000));
    send_item(OP_CHECK,   32'h5A5A_5A5A, TIME_TOP);
    send_item(OP_SWEEP,   32'hA5A5_A5A5, '0);

    // Random part. Traffic comes from a pool of sources so that buckets fill
    // and drain; a tenth of the requests use fresh addresses. Every fifth
    // phase uses a pool larger than the table and few sweeps, so inserts
    // run into a full table.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p % 7)
        0: set_limits('1, '1);
        1: set_limits(CFG_W'(1), '0);
        2: set_limits('0, CFG_W'($urandom));
        4: set_limits(CFG_W'(RATE_RESET), CFG_W'(1));
        5: set_limits(CFG_W'($urandom_range(1, 600)), CFG_W'($urandom_range(0, 30)));
        default: set_limits(CFG_W'($urandom), CFG_W'($urandom));
      endcase
      calm = (p % 4 == 2);
      pool_size = (p % 5 == 4) ? POOL_MAX : $urandom_range(4, 40);
      sweep_share = (p % 5 == 4) ? 4 : 20;
      for (int k = 0; k < pool_size; k++) pool[k] = $urandom;
      clock_ms = {8'($urandom_range(0, 255)), 32'($urandom)};

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < sweep_share) op = OP_SWEEP;
        else if (roll < sweep_share + 12) op = OP_TIMEOUT;
        else if (roll < 60) op = OP_REQUEST;
        else op = OP_CHECK;
        addr = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom)
                                            : pool[$urandom_range(0, pool_size - 1)];
        // Time mostly creeps forward so buckets stay partly full; sometimes
        // it jumps far ahead (wrapping at the top) or steps back.
        roll = $urandom_range(0, 99);
        if (roll < 70) clock_ms = clock_ms + TIME_W'($urandom_range(0, 40));
        else if (roll < 90) clock_ms = clock_ms + TIME_W'($urandom_range(41, 3000));
        else if (roll < 96) clock_ms = clock_ms + {8'($urandom_range(0, 255)), 32'($urandom)};
        else clock_ms = clock_ms - TIME_W'($urandom_range(1, 5000));
        send_item(op, addr, clock_ms);
      end
    end

    // Drain: every response in, then a scan's worth of cycles to catch any
    // stray response before the verdict.
    calm = 1'b0;
    wait_idle();
    repeat (100) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("per_source_leaky_bucket_limiter verification clean");
    end else begin
      $display("per_source_leaky_bucket_limiter verification failed");
    end
    $finish;
  end

endmodule
